// ----- design/rational_arithmetic_unit_defines.svh -----
// assertion macros for the rational arithmetic unit
// no dependencies; included by the top level
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rau check failed");
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rau check failed");
`else
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/rau_pkg.sv -----
// shared codes for the rational arithmetic unit
// no dependencies
package rau_pkg;
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
	localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_GCD   = 10'b0000000010,
		S_GCD_W = 10'b0000000100,
		S_DA    = 10'b0000001000,
		S_DB    = 10'b0000010000,
		S_MUL   = 10'b0000100000,
		S_FIX   = 10'b0001000000,
		S_DP    = 10'b0010000000,
		S_DQ    = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;
endpackage

// ----- design/rau_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// standalone; instantiated by the top level
module rau_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W);

	logic [W-1:0]  quot_q, rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, done_q;
	logic [W:0]    sh;
	logic          fits;

	assign sh   = {rem_q, quot_q[W-1]};
	assign fits = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q  <= W'(sh - {1'b0, dvs_q});
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= sh[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

// ----- design/rational_arithmetic_unit.sv -----
// rational arithmetic unit: run time grows with the number of divider passes;
// the gcd loops dominate, and a zero numerator product skips the reduction pass
// an error item strobes in the cycle right after acceptance; one item at a time
// for a non-error item busy stays high until the result strobe; the receiver cannot stall
// arst_n clears the sequencer, strobe and busy; data registers are not reset
// depends on rau_pkg, rau_div and rational_arithmetic_unit_defines.svh
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [OPERAND_BITS-1:0] num_a,
	input  logic [OPERAND_BITS-2:0] den_a,
	input  logic [OPERAND_BITS-1:0] num_b,
	input  logic [OPERAND_BITS-2:0] den_b,
	output logic                    res_valid,
	output logic [31:0]             res_num,
	output logic [30:0]             res_den,
	output logic                    is_whole,
	output logic [1:0]              error_code
);
	localparam int N  = OPERAND_BITS;
	localparam int DW = 2 * N;   // raw results fit here, signed or magnitude

	rau_pkg::state_t state_q;

	// latched operands
	logic [1:0]          op_q;
	logic signed [N-1:0] pa_q, pb_q;
	logic [N-2:0]        qa_q, qb_q;

	// gcd working pair, reduced denominators, raw result
	logic [DW-1:0]        ga_q, gb_q, t1_q, t2_q;
	logic signed [DW-1:0] p_q, q_q, mul_q;
	logic                 red_q;     // second gcd pass (result reduction)
	logic [1:0]           mstep_q;

	logic        strobe_q, whole_q;
	logic [31:0] num_q;
	logic [30:0] den_q;
	logic [1:0]  err_q;

	// divider hookup
	logic          div_start, div_done;
	logic [DW-1:0] div_dvd, div_dvs, div_quot, div_rem;

	rau_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	logic [DW-1:0] p_mag;
	assign p_mag = p_q[DW-1] ? DW'(-p_q) : DW'(p_q);

	// divider operand select per sequencer step
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		case (state_q)
			rau_pkg::S_GCD: begin
				if (gb_q != '0) begin
					div_start = 1'b1;
					div_dvd   = ga_q;
					div_dvs   = gb_q;
				end else if (!red_q) begin
					// lcm factor qa/g
					div_start = 1'b1;
					div_dvd   = DW'(qa_q);
					div_dvs   = ga_q;
				end else if (ga_q > DW'(1)) begin
					div_start = 1'b1;
					div_dvd   = p_mag;
					div_dvs   = ga_q;
				end
			end
			rau_pkg::S_DA: begin
				div_start = div_done;
				div_dvd   = DW'(qb_q);
				div_dvs   = ga_q;
			end
			rau_pkg::S_DP: begin
				div_start = div_done;
				div_dvd   = DW'(q_q);
				div_dvs   = ga_q;
			end
			default: begin
			end
		endcase
	end

	// shared multiplier, operands one bit wider than the numerators
	logic signed [N:0]     mul_a, mul_b;
	logic signed [2*N+1:0] prod;
	logic                  is_addsub;

	assign is_addsub = op_q inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mstep_q)
			2'd0: begin
				if (is_addsub) begin
					mul_a = $signed({1'b0, t1_q[N-1:0]});
					mul_b = $signed({2'b00, qb_q});
				end else if (op_q == rau_pkg::OP_MUL) begin
					mul_a = $signed({pa_q[N-1], pa_q});
					mul_b = $signed({pb_q[N-1], pb_q});
				end else begin
					mul_a = $signed({pa_q[N-1], pa_q});
					mul_b = $signed({2'b00, qb_q});
				end
			end
			2'd1: begin
				if (is_addsub) begin
					mul_a = $signed({1'b0, t2_q[N-1:0]});
					mul_b = $signed({pa_q[N-1], pa_q});
				end else begin
					mul_a = $signed({2'b00, qa_q});
					mul_b = (op_q == rau_pkg::OP_MUL) ? $signed({2'b00, qb_q})
					                                  : $signed({pb_q[N-1], pb_q});
				end
			end
			2'd2: begin
				mul_a = $signed({1'b0, t1_q[N-1:0]});
				mul_b = $signed({pb_q[N-1], pb_q});
			end
			default: begin
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// divide with a negative denominator moves the sign up
	logic                 flip;
	logic signed [DW-1:0] p_fix, q_fix;
	assign flip  = (op_q == rau_pkg::OP_DIV) && q_q[DW-1];
	assign p_fix = flip ? -p_q : p_q;
	assign q_fix = flip ? -q_q : q_q;

	logic [63:0] p_wide, q_wide;
	assign p_wide = 64'(p_q);
	assign q_wide = 64'(q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rau_pkg::S_IDLE;
			strobe_q <= 1'b0;
			red_q    <= 1'b0;
			mstep_q  <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				rau_pkg::S_IDLE: begin
					if (start) begin
						red_q <= 1'b0;
						if (den_a == '0 || den_b == '0) begin
							strobe_q <= 1'b1;
						end else if (op == rau_pkg::OP_DIV && num_b == '0) begin
							strobe_q <= 1'b1;
						end else if (op inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB}) begin
							state_q <= rau_pkg::S_GCD;
						end else begin
							mstep_q <= '0;
							state_q <= rau_pkg::S_MUL;
						end
					end
				end
				rau_pkg::S_GCD: begin
					if (gb_q != '0) begin
						state_q <= rau_pkg::S_GCD_W;
					end else if (!red_q) begin
						state_q <= rau_pkg::S_DA;
					end else if (ga_q > DW'(1)) begin
						state_q <= rau_pkg::S_DP;
					end else begin
						state_q <= rau_pkg::S_OUT;
					end
				end
				rau_pkg::S_GCD_W: begin
					if (div_done) state_q <= rau_pkg::S_GCD;
				end
				rau_pkg::S_DA: begin
					if (div_done) state_q <= rau_pkg::S_DB;
				end
				rau_pkg::S_DB: begin
					if (div_done) begin
						mstep_q <= '0;
						state_q <= rau_pkg::S_MUL;
					end
				end
				rau_pkg::S_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 2'd3) state_q <= rau_pkg::S_FIX;
				end
				rau_pkg::S_FIX: begin
					if (p_fix == '0) begin
						state_q <= rau_pkg::S_OUT;
					end else begin
						red_q   <= 1'b1;
						state_q <= rau_pkg::S_GCD;
					end
				end
				rau_pkg::S_DP: begin
					if (div_done) state_q <= rau_pkg::S_DQ;
				end
				rau_pkg::S_DQ: begin
					if (div_done) state_q <= rau_pkg::S_OUT;
				end
				rau_pkg::S_OUT: begin
					strobe_q <= 1'b1;
					state_q  <= rau_pkg::S_IDLE;
				end
				default: begin
					state_q <= rau_pkg::S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= prod[DW-1:0];
		case (state_q)
			rau_pkg::S_IDLE: begin
				op_q <= op;
				pa_q <= num_a;
				pb_q <= num_b;
				qa_q <= den_a;
				qb_q <= den_b;
				ga_q <= DW'(den_a);
				gb_q <= DW'(den_b);
				num_q <= '0;
				den_q <= '0;
				whole_q <= 1'b0;
				if (den_a == '0 || den_b == '0) begin
					err_q <= rau_pkg::ERR_ZERO_DEN;
				end else if (op == rau_pkg::OP_DIV && num_b == '0) begin
					err_q <= rau_pkg::ERR_DIV_ZERO;
				end else begin
					err_q <= rau_pkg::ERR_NONE;
				end
			end
			rau_pkg::S_GCD_W: begin
				if (div_done) begin
					ga_q <= gb_q;
					gb_q <= div_rem;
				end
			end
			rau_pkg::S_DA: begin
				if (div_done) t1_q <= div_quot;
			end
			rau_pkg::S_DB: begin
				if (div_done) t2_q <= div_quot;
			end
			rau_pkg::S_MUL: begin
				case (mstep_q)
					2'd1: begin
						if (is_addsub) q_q <= mul_q;
						else p_q <= mul_q;
					end
					2'd2: begin
						if (is_addsub) p_q <= mul_q;
						else q_q <= mul_q;
					end
					2'd3: begin
						if (is_addsub) begin
							p_q <= (op_q == rau_pkg::OP_ADD) ? p_q + mul_q : p_q - mul_q;
						end
					end
					default: begin
					end
				endcase
			end
			rau_pkg::S_FIX: begin
				p_q  <= p_fix;
				q_q  <= q_fix;
				ga_q <= p_fix[DW-1] ? DW'(-p_fix) : DW'(p_fix);
				gb_q <= DW'(q_fix);
			end
			rau_pkg::S_DP: begin
				if (div_done) p_q <= p_q[DW-1] ? -$signed(div_quot) : $signed(div_quot);
			end
			rau_pkg::S_DQ: begin
				if (div_done) q_q <= $signed(div_quot);
			end
			rau_pkg::S_OUT: begin
				num_q   <= p_wide[31:0];
				den_q   <= q_wide[30:0];
				whole_q <= q_q == DW'(1);
			end
			default: begin
			end
		endcase
	end

	assign busy       = state_q != rau_pkg::S_IDLE;
	assign res_valid  = strobe_q;
	assign res_num    = num_q;
	assign res_den    = den_q;
	assign is_whole   = whole_q;
	assign error_code = err_q;

	// a result only shows once the sequencer is back at rest
	`RAU_ASSERT_IMPL(a_strobe_idle, clk, arst_n, res_valid, !busy)
	// error results carry no fraction
	`RAU_ASSERT_IMPL(a_err_clear, clk, arst_n, res_valid && error_code != rau_pkg::ERR_NONE, res_num == '0 && res_den == '0 && !is_whole)
	// an accepted item either starts work or answers at once
	`RAU_ASSERT_NEXT(a_accept, clk, arst_n, start && !busy, busy || res_valid)
endmodule
